FILE: rtl/uart_bootloader_flash_programmer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bootloader flash programmer
// Shared shorthand for the clocked properties used in the RTL.
// ----------------------------------------------------------------------------
`ifndef UART_BOOTLOADER_FLASH_PROGRAMMER_MACROS_SVH
`define UART_BOOTLOADER_FLASH_PROGRAMMER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define UBFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define UBFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ubfp_pkg.sv
// ----------------------------------------------------------------------------
// ubfp_pkg
// Types and constants shared by the bootloader flash programmer modules.
// ----------------------------------------------------------------------------
package ubfp_pkg;

    localparam int PAGE_BYTES = 256;

    localparam logic [15:0] ERASE_COUNT_RESET   = 16'd700;
    localparam logic [31:0] START_ADDRESS_RESET = 32'h0800_0000;

    // Configuration register indexes.
    localparam logic [0:0] REG_ERASE_COUNT   = 1'b0;
    localparam logic [0:0] REG_START_ADDRESS = 1'b1;

    // Input item commands.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_READY = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;
    localparam logic [1:0] CMD_IMAGE = 2'd3;

    // Reported status codes.
    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_SENDING     = 3'd1;
    localparam logic [2:0] ST_AWAIT_REPLY = 3'd2;
    localparam logic [2:0] ST_AWAIT_IMAGE = 3'd3;
    localparam logic [2:0] ST_DONE        = 3'd4;
    localparam logic [2:0] ST_NACK        = 3'd5;
    localparam logic [2:0] ST_UNKNOWN     = 3'd6;

    typedef struct packed {
        logic [16:0] page_index;
        logic [2:0]  status;
        logic [7:0]  tx_byte;
        logic        tx_valid;
    } result_t;

endpackage

FILE: rtl/uart_bootloader_flash_programmer.sv
// ----------------------------------------------------------------------------
// uart_bootloader_flash_programmer
// Host-side sequencer that erases and programs a target flash over a serial
// bootloader exchange, one transmitted byte per item.
// ----------------------------------------------------------------------------
// Usage:
// Each input item carries a command in s_tuser: start session (with the image
// length), transmitter ready, reply byte arrived, or image byte supplied.
// Each accepted item yields exactly one result item on the master side with
// the byte to transmit (valid flag in m_tuser), the session status and the
// number of pages already programmed.
// An accepted item sits in the input register; its result is loaded into the result
// register once that register is free, and m_tvalid is high from then on.
// Throughput is one item per cycle while m_tready stays high; the session update
// is a single pass of short logic between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; further input waits until m_tready returns.
// Reset clears both valid flags and returns the session to idle, with the
// erase count at 700 and the start address at 0x08000000. The configuration
// port writes erase_count (index 0) and start_address (index 1) directly.
// ----------------------------------------------------------------------------
module uart_bootloader_flash_programmer (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // image_bytes[23:0], reply[31:24], image_data[39:32]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], status[10:8], page_index[27:11]
    output logic [0:0]  m_tuser,   // tx_valid[0]
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ubfp_pkg::*;

    logic        in_valid_reg;
    logic [39:0] in_data_reg;
    logic [1:0]  in_cmd_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic [15:0] erase_count_reg;
    logic [31:0] start_address_reg;
    logic        advance;
    result_t     core_result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_count_reg   <= ERASE_COUNT_RESET;
            start_address_reg <= START_ADDRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ERASE_COUNT:   erase_count_reg   <= cfg_data[15:0];
                REG_START_ADDRESS: start_address_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_cmd_reg  <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    ubfp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .command       (in_cmd_reg),
        .image_bytes   (in_data_reg[23:0]),
        .reply         (in_data_reg[31:24]),
        .image_data    (in_data_reg[39:32]),
        .erase_count   (erase_count_reg),
        .start_address (start_address_reg),
        .result        (core_result)
    );

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'd0, out_data_reg.page_index, out_data_reg.status,
                         out_data_reg.tx_byte};
    assign m_tuser[0] = out_data_reg.tx_valid;

endmodule

FILE: rtl/ubfp_core.sv
// ----------------------------------------------------------------------------
// ubfp_core
// Session state and per-item sequencing of the bootloader exchange.
// ----------------------------------------------------------------------------
`include "uart_bootloader_flash_programmer_macros.svh"

module ubfp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         command,
    input  logic [23:0]        image_bytes,
    input  logic [7:0]         reply,
    input  logic [7:0]         image_data,
    input  logic [15:0]        erase_count,
    input  logic [31:0]        start_address,
    output ubfp_pkg::result_t  result
);
    import ubfp_pkg::*;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_SYNC    = 4'd1;
    localparam logic [3:0] PH_W_SYNC  = 4'd2;
    localparam logic [3:0] PH_ECMD    = 4'd3;
    localparam logic [3:0] PH_W_ECMD  = 4'd4;
    localparam logic [3:0] PH_ELIST   = 4'd5;
    localparam logic [3:0] PH_W_ELIST = 4'd6;
    localparam logic [3:0] PH_WCMD    = 4'd7;
    localparam logic [3:0] PH_W_WCMD  = 4'd8;
    localparam logic [3:0] PH_ADDR    = 4'd9;
    localparam logic [3:0] PH_W_ADDR  = 4'd10;
    localparam logic [3:0] PH_PAGE    = 4'd11;
    localparam logic [3:0] PH_W_PAGE  = 4'd12;
    localparam logic [3:0] PH_DONE    = 4'd13;
    localparam logic [3:0] PH_NACK    = 4'd14;
    localparam logic [3:0] PH_UNK     = 4'd15;

    localparam logic [7:0]  SYNC_BYTE  = 8'h7F;
    localparam logic [7:0]  ERASE_B0   = 8'h44;
    localparam logic [7:0]  ERASE_B1   = 8'hBB;
    localparam logic [7:0]  WRITE_B0   = 8'h31;
    localparam logic [7:0]  WRITE_B1   = 8'hCE;
    localparam logic [7:0]  ACK_BYTE   = 8'h79;
    localparam logic [7:0]  NACK_BYTE  = 8'h1F;
    localparam logic [7:0]  LEN_BYTE   = 8'(PAGE_BYTES - 1);
    localparam logic [17:0] PAGE_STEPS = 18'(PAGE_BYTES);

    logic [3:0]  phase_reg,  phase_next;
    logic [17:0] step_reg,   step_next;
    logic [7:0]  xor_reg,    xor_next;
    logic [31:0] addr_reg,   addr_next;
    logic [16:0] done_reg,   done_next;
    logic [16:0] total_reg,  total_next;

    logic [17:0] elist_last;
    logic [17:0] elist_k;
    logic [16:0] elist_pg;
    logic [7:0]  elist_byte;
    logic [7:0]  addr_byte;
    logic [24:0] len_round;
    logic [24:0] len_pages;
    logic [16:0] pages_sat;
    logic [16:0] done_inc;
    logic        waiting;
    logic        page_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;

    function automatic logic [2:0] phase_status(input logic [3:0] ph, input logic [17:0] st);
        logic [2:0] code;
        case (ph)
            PH_IDLE:  code = ST_IDLE;
            PH_SYNC, PH_ECMD, PH_ELIST, PH_WCMD, PH_ADDR:
                code = ST_SENDING;
            PH_PAGE:  code = (st >= 18'd1 && st <= PAGE_STEPS) ? ST_AWAIT_IMAGE : ST_SENDING;
            PH_DONE:  code = ST_DONE;
            PH_NACK:  code = ST_NACK;
            PH_UNK:   code = ST_UNKNOWN;
            default:  code = ST_AWAIT_REPLY;
        endcase
        return code;
    endfunction

    // Erase list: count high, count low, then each page number big-endian.
    assign elist_last = {1'b0, erase_count, 1'b0} + 18'd4;
    assign elist_k    = step_reg - 18'd2;
    assign elist_pg   = elist_k[17:1];
    always_comb
    begin
        case (step_reg)
            18'd0:   elist_byte = erase_count[15:8];
            18'd1:   elist_byte = erase_count[7:0];
            default: elist_byte = elist_k[0] ? elist_pg[7:0] : elist_pg[15:8];
        endcase
    end

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    addr_byte = addr_reg[31:24];
            2'd1:    addr_byte = addr_reg[23:16];
            2'd2:    addr_byte = addr_reg[15:8];
            default: addr_byte = addr_reg[7:0];
        endcase
    end

    assign len_round = {1'b0, image_bytes} + 25'(PAGE_BYTES - 1);
    assign len_pages = len_round / 25'(PAGE_BYTES);
    assign pages_sat = (len_pages > 25'h1FFFF) ? 17'h1FFFF : len_pages[16:0];
    assign done_inc  = done_reg + 17'd1;

    assign waiting = (phase_reg == PH_W_SYNC) || (phase_reg == PH_W_ECMD) ||
                     (phase_reg == PH_W_ELIST) || (phase_reg == PH_W_WCMD) ||
                     (phase_reg == PH_W_ADDR) || (phase_reg == PH_W_PAGE);
    assign page_data = (phase_reg == PH_PAGE) && (step_reg >= 18'd1) &&
                       (step_reg <= PAGE_STEPS);

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        xor_next   = xor_reg;
        addr_next  = addr_reg;
        done_next  = done_reg;
        total_next = total_reg;
        tx_valid   = 1'b0;
        tx_byte    = 8'd0;
        case (command)
            CMD_START:
            begin
                total_next = pages_sat;
                done_next  = 17'd0;
                addr_next  = start_address;
                phase_next = PH_SYNC;
                step_next  = 18'd0;
                xor_next   = 8'd0;
            end
            CMD_READY:
            begin
                case (phase_reg)
                    PH_SYNC:
                    begin
                        tx_valid   = 1'b1;
                        tx_byte    = SYNC_BYTE;
                        phase_next = PH_W_SYNC;
                        step_next  = 18'd0;
                        xor_next   = 8'd0;
                    end
                    PH_ECMD, PH_WCMD:
                    begin
                        tx_valid = 1'b1;
                        if (phase_reg == PH_ECMD)
                        begin
                            tx_byte = (step_reg == 18'd0) ? ERASE_B0 : ERASE_B1;
                        end
                        else
                        begin
                            tx_byte = (step_reg == 18'd0) ? WRITE_B0 : WRITE_B1;
                        end
                        step_next = step_reg + 18'd1;
                        if (step_reg != 18'd0)
                        begin
                            phase_next = (phase_reg == PH_ECMD) ? PH_W_ECMD : PH_W_WCMD;
                            step_next  = 18'd0;
                            xor_next   = 8'd0;
                        end
                    end
                    PH_ELIST:
                    begin
                        tx_valid = 1'b1;
                        if (step_reg >= elist_last)
                        begin
                            tx_byte    = xor_reg;
                            phase_next = PH_W_ELIST;
                            step_next  = 18'd0;
                            xor_next   = 8'd0;
                        end
                        else
                        begin
                            tx_byte   = elist_byte;
                            xor_next  = xor_reg ^ elist_byte;
                            step_next = step_reg + 18'd1;
                        end
                    end
                    PH_ADDR:
                    begin
                        tx_valid = 1'b1;
                        if (step_reg >= 18'd4)
                        begin
                            tx_byte    = xor_reg;
                            phase_next = PH_W_ADDR;
                            step_next  = 18'd0;
                            xor_next   = 8'd0;
                        end
                        else
                        begin
                            tx_byte   = addr_byte;
                            xor_next  = xor_reg ^ addr_byte;
                            step_next = step_reg + 18'd1;
                        end
                    end
                    PH_PAGE:
                    begin
                        if (step_reg == 18'd0)
                        begin
                            tx_valid  = 1'b1;
                            tx_byte   = LEN_BYTE;
                            xor_next  = xor_reg ^ LEN_BYTE;
                            step_next = 18'd1;
                        end
                        else if (step_reg > PAGE_STEPS)
                        begin
                            tx_valid   = 1'b1;
                            tx_byte    = xor_reg;
                            phase_next = PH_W_PAGE;
                            step_next  = 18'd0;
                            xor_next   = 8'd0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_REPLY:
            begin
                if (waiting)
                begin
                    step_next = 18'd0;
                    xor_next  = 8'd0;
                    if (reply == ACK_BYTE)
                    begin
                        case (phase_reg)
                            PH_W_SYNC:  phase_next = PH_ECMD;
                            PH_W_ECMD:  phase_next = PH_ELIST;
                            PH_W_ELIST: phase_next = (total_reg != 17'd0) ? PH_WCMD : PH_DONE;
                            PH_W_WCMD:  phase_next = PH_ADDR;
                            PH_W_ADDR:  phase_next = PH_PAGE;
                            default:
                            begin
                                // Page acknowledged: advance to the next page or finish.
                                done_next  = done_inc;
                                addr_next  = addr_reg + 32'(PAGE_BYTES);
                                phase_next = (done_inc >= total_reg) ? PH_DONE : PH_WCMD;
                            end
                        endcase
                    end
                    else if (reply == NACK_BYTE)
                    begin
                        phase_next = PH_NACK;
                    end
                    else
                    begin
                        phase_next = PH_UNK;
                    end
                end
            end
            default:
            begin
                if (page_data)
                begin
                    tx_valid  = 1'b1;
                    tx_byte   = image_data;
                    xor_next  = xor_reg ^ image_data;
                    step_next = step_reg + 18'd1;
                end
            end
        endcase
    end

    assign result.tx_valid   = tx_valid;
    assign result.tx_byte    = tx_byte;
    assign result.status     = phase_status(phase_next, step_next);
    assign result.page_index = done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= 18'd0;
            xor_reg   <= 8'd0;
            addr_reg  <= 32'd0;
            done_reg  <= 17'd0;
            total_reg <= 17'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            xor_reg   <= xor_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
            total_reg <= total_next;
        end
    end

    `UBFP_ASSERT_NEXT(a_start_restarts, step && command == CMD_START, phase_reg == PH_SYNC && done_reg == 17'd0, "start did not restart the session")
    `UBFP_ASSERT_NEXT(a_hold_without_step, !step, $stable(phase_reg) && $stable(step_reg) && $stable(done_reg), "session state moved without an item")
    `UBFP_ASSERT_NOW(a_pages_bounded, 1'b1, done_reg <= total_reg, "more pages programmed than the image holds")
    `UBFP_ASSERT_NOW(a_page_step_bounded, phase_reg == PH_PAGE, step_reg <= PAGE_STEPS + 18'd1, "page byte counter overran")
    `UBFP_ASSERT_NOW(a_tx_status, step && result.tx_valid, result.status == ST_SENDING || result.status == ST_AWAIT_REPLY || result.status == ST_AWAIT_IMAGE, "byte sent outside an active session")

endmodule

FILE: test/tb_uart_bootloader_flash_programmer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the bootloader flash programmer
// Drives command items into the stream input and checks every result item
// against an in-bench model of the erase and program session. A short table
// of directed items comes first, then random sessions under several register
// settings, with random gaps on the input side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_uart_bootloader_flash_programmer;

    import ubfp_pkg::*;

    localparam int          LIMIT        = 1_000_000;
    localparam int          PHASE_ITEMS  = 490;
    localparam int          NUM_PHASES   = 4;
    localparam logic [7:0]  SYNC_BYTE    = 8'h7F;
    localparam logic [7:0]  ERASE_CMD    = 8'h44;
    localparam logic [7:0]  WRITE_CMD    = 8'h31;
    localparam logic [7:0]  ACK_BYTE     = 8'h79;
    localparam logic [7:0]  NACK_BYTE    = 8'h1F;

    typedef enum logic [3:0] {
        P_IDLE, P_SYNC, P_W_SYNC, P_ECMD, P_W_ECMD, P_ELIST, P_W_ELIST, P_WCMD,
        P_W_WCMD, P_ADDR, P_W_ADDR, P_PAGE, P_W_PAGE, P_DONE, P_NACK, P_UNK
    } session_t;

    typedef struct {
        bit          is_regs;
        logic [15:0] erase_val;
        logic [31:0] addr_val;
        logic [1:0]  cmd;
        logic [23:0] len;
        logic [7:0]  rep;
        logic [7:0]  dat;
        bit          known;
        result_t     want;
    } row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // image_bytes[23:0], reply[31:24], image_data[39:32]
    logic [1:0]  s_tuser   = '0;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // tx_byte[7:0], status[10:8], page_index[27:11]
    logic [0:0]  m_tuser;          // tx_valid[0]
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Session model.
    session_t    ph;
    logic [17:0] step;
    logic [7:0]  xsum;
    logic [31:0] taddr;
    logic [16:0] pages_done;
    logic [16:0] pages_total;
    logic [15:0] erase_cnt;
    logic [31:0] base_addr;
    bit          acted;

    result_t     pending_results[$];
    int unsigned errors      = 0;
    int unsigned cycles      = 0;
    int unsigned stall_left  = 0;
    bit          src_quiet   = 1'b0;
    bit          sink_quiet  = 1'b0;
    result_t     seen;
    result_t     want_now;

    uart_bootloader_flash_programmer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void enter_phase(session_t p);
        ph   = p;
        step = '0;
        xsum = '0;
    endfunction

    function automatic logic [2:0] session_status();
        case (ph)
            P_IDLE:                                  return ST_IDLE;
            P_SYNC, P_ECMD, P_ELIST, P_WCMD, P_ADDR: return ST_SENDING;
            P_PAGE:  return (step >= 1 && step <= PAGE_BYTES) ? ST_AWAIT_IMAGE : ST_SENDING;
            P_DONE:                                  return ST_DONE;
            P_NACK:                                  return ST_NACK;
            P_UNK:                                   return ST_UNKNOWN;
            default:                                 return ST_AWAIT_REPLY;
        endcase
    endfunction

    // Produces the next byte of the current group on transmitter ready.
    function automatic bit next_tx_byte(output logic [7:0] b);
        logic [17:0] s;
        logic [17:0] last;
        logic [17:0] k;
        logic [31:0] shifted;
        s = step;
        b = '0;
        case (ph)
            P_SYNC:
            begin
                b = SYNC_BYTE;
                enter_phase(P_W_SYNC);
            end
            P_ECMD, P_WCMD:
            begin
                if (ph == P_ECMD)
                    b = (s == 0) ? ERASE_CMD : ~ERASE_CMD;
                else
                    b = (s == 0) ? WRITE_CMD : ~WRITE_CMD;
                step = s + 18'd1;
                if (step >= 2)
                    enter_phase(ph == P_ECMD ? P_W_ECMD : P_W_WCMD);
            end
            P_ELIST:
            begin
                last = {1'b0, erase_cnt, 1'b0} + 18'd4;
                if (s >= last)
                begin
                    b = xsum;
                    enter_phase(P_W_ELIST);
                end
                else
                begin
                    if (s == 0)
                        b = erase_cnt[15:8];
                    else if (s == 1)
                        b = erase_cnt[7:0];
                    else
                    begin
                        // Page numbers go out big-endian, two bytes each.
                        k = s - 18'd2;
                        b = k[0] ? k[8:1] : k[16:9];
                    end
                    xsum ^= b;
                    step = s + 18'd1;
                end
            end
            P_ADDR:
            begin
                if (s >= 4)
                begin
                    b = xsum;
                    enter_phase(P_W_ADDR);
                end
                else
                begin
                    shifted = taddr << (8 * s[1:0]);
                    b = shifted[31:24];
                    xsum ^= b;
                    step = s + 18'd1;
                end
            end
            P_PAGE:
            begin
                if (s == 0)
                begin
                    b = 8'(PAGE_BYTES - 1);
                    xsum ^= b;
                    step = 18'd1;
                end
                else if (s > PAGE_BYTES)
                begin
                    b = xsum;
                    enter_phase(P_W_PAGE);
                end
                else
                    return 1'b0;
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void take_ack();
        case (ph)
            P_W_SYNC:  enter_phase(P_ECMD);
            P_W_ECMD:  enter_phase(P_ELIST);
            P_W_ELIST: enter_phase(pages_total != 0 ? P_WCMD : P_DONE);
            P_W_WCMD:  enter_phase(P_ADDR);
            P_W_ADDR:  enter_phase(P_PAGE);
            P_W_PAGE:
            begin
                pages_done = pages_done + 17'd1;
                taddr      = taddr + 32'(PAGE_BYTES);
                enter_phase(pages_done >= pages_total ? P_DONE : P_WCMD);
            end
            default: ;
        endcase
    endfunction

    // Advances the session by one accepted item and returns its result.
    function automatic result_t session_step(logic [1:0] cmd, logic [23:0] len,
                                             logic [7:0] rep, logic [7:0] dat);
        result_t     r;
        logic [7:0]  b;
        logic        v;
        logic [24:0] pages;
        b     = '0;
        v     = 1'b0;
        acted = 1'b1;
        case (cmd)
            CMD_START:
            begin
                pages       = ({1'b0, len} + 25'(PAGE_BYTES - 1)) / 25'(PAGE_BYTES);
                pages_total = (pages > 25'h1FFFF) ? 17'h1FFFF : pages[16:0];
                pages_done  = '0;
                taddr       = base_addr;
                enter_phase(P_SYNC);
            end
            CMD_READY:
            begin
                v     = next_tx_byte(b);
                acted = v;
            end
            CMD_REPLY:
            begin
                if (ph inside {P_W_SYNC, P_W_ECMD, P_W_ELIST, P_W_WCMD, P_W_ADDR, P_W_PAGE})
                begin
                    if (rep == ACK_BYTE)
                        take_ack();
                    else if (rep == NACK_BYTE)
                        enter_phase(P_NACK);
                    else
                        enter_phase(P_UNK);
                end
                else
                    acted = 1'b0;
            end
            default:
            begin
                if (ph == P_PAGE && step >= 1 && step <= PAGE_BYTES)
                begin
                    b    = dat;
                    xsum ^= b;
                    step = step + 18'd1;
                    v    = 1'b1;
                end
                else
                    acted = 1'b0;
            end
        endcase
        r.tx_valid   = v;
        r.tx_byte    = v ? b : 8'h00;
        r.status     = session_status();
        r.page_index = pages_done;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none during a quiet stretch.
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic row_t stim_row(logic [1:0] cmd, logic [23:0] len,
                                      logic [7:0] rep, logic [7:0] dat);
        row_t w;
        w         = '{default: '0};
        w.cmd     = cmd;
        w.len     = len;
        w.rep     = rep;
        w.dat     = dat;
        return w;
    endfunction

    function automatic row_t known_row(logic [1:0] cmd, logic [23:0] len, logic [7:0] rep,
                                       logic [7:0] dat, logic v, logic [7:0] b,
                                       logic [2:0] st, logic [16:0] pg);
        row_t w;
        w       = stim_row(cmd, len, rep, dat);
        w.known = 1'b1;
        w.want  = '{page_index: pg, status: st, tx_byte: b, tx_valid: v};
        return w;
    endfunction

    function automatic row_t regs_row(logic [15:0] e, logic [31:0] a);
        row_t w;
        w           = '{default: '0};
        w.is_regs   = 1'b1;
        w.erase_val = e;
        w.addr_val  = a;
        return w;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [23:0] len, logic [7:0] rep,
                             logic [7:0] dat, bit known, result_t want);
        result_t     r;
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dat, rep, len};
        do
            @(posedge clk);
        while (!s_tready);
        r = session_step(cmd, len, rep, dat);
        pending_results.push_back(known ? want : r);
        if ($urandom_range(0, 49) == 0)
            src_quiet = !src_quiet;
        gap = pick_gap(src_quiet);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Registers change only once every result of earlier items is back.
    task automatic set_regs(logic [15:0] e, logic [31:0] a);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ERASE_COUNT;
        cfg_data  <= {16'h0000, e};
        @(posedge clk);
        cfg_index <= REG_START_ADDRESS;
        cfg_data  <= a;
        @(posedge clk);
        cfg_we    <= 1'b0;
        erase_cnt = e;
        base_addr = a;
    endtask

    // Result side: check every accepted result and stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen = '{page_index: m_tdata[27:11], status: m_tdata[10:8],
                         tx_byte: m_tdata[7:0], tx_valid: m_tuser[0]};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with nothing expected: valid %0d byte %02h status %0d page %0d",
                                 $realtime, seen.tx_valid, seen.tx_byte, seen.status,
                                 seen.page_index);
                end
                else
                begin
                    want_now = pending_results.pop_front();
                    if (seen !== want_now)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch: expected valid %0d byte %02h status %0d page %0d, got valid %0d byte %02h status %0d page %0d",
                                     $realtime, want_now.tx_valid, want_now.tx_byte,
                                     want_now.status, want_now.page_index, seen.tx_valid,
                                     seen.tx_byte, seen.status, seen.page_index);
                    end
                end
            end
            if ($urandom_range(0, 49) == 0)
                sink_quiet = !sink_quiet;
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap(sink_quiet);
                if (stall_left == 0)
                    m_tready <= 1'b1;
                else
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        row_t        plan[$];
        int unsigned counted;
        int unsigned pick;
        logic [1:0]  cmd;
        logic [23:0] len;
        logic [7:0]  rep;
        logic [7:0]  dat;
        logic [15:0] e;
        logic [31:0] a;

        erase_cnt   = ERASE_COUNT_RESET;
        base_addr   = START_ADDRESS_RESET;
        ph          = P_IDLE;
        step        = '0;
        xsum        = '0;
        taddr       = '0;
        pages_done  = '0;
        pages_total = '0;

        // Reset settings: erase count 700 goes out as 0x02 0xBC.
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 0, 8'h00, ST_IDLE, 0));
        plan.push_back(known_row(CMD_START, 24'hFF_FFFF, 8'hFF, 8'h00,
                                 0, 8'h00, ST_SENDING, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 1, SYNC_BYTE, ST_AWAIT_REPLY, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 0, 8'h00, ST_AWAIT_REPLY, 0));
        plan.push_back(stim_row(CMD_REPLY, 0, ACK_BYTE, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 1, ERASE_CMD, ST_SENDING, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 1, ~ERASE_CMD, ST_AWAIT_REPLY, 0));
        plan.push_back(stim_row(CMD_REPLY, 0, ACK_BYTE, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 1, 8'h02, ST_SENDING, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 1, 8'hBC, ST_SENDING, 0));
        plan.push_back(known_row(CMD_IMAGE, 0, 0, 8'h5A, 0, 8'h00, ST_SENDING, 0));
        // Restart in the middle of the erase list, then an unknown reply.
        plan.push_back(stim_row(CMD_START, 0, 0, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(known_row(CMD_REPLY, 0, 8'hA5, 0, 0, 8'h00, ST_UNKNOWN, 0));
        plan.push_back(stim_row(CMD_START, 24'd1, 0, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(known_row(CMD_REPLY, 0, NACK_BYTE, 0, 0, 8'h00, ST_NACK, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 0, 8'h00, ST_NACK, 0));
        // Empty image with the shortest erase list ends after the erase.
        plan.push_back(regs_row(16'h0000, 32'hFFFF_FFFF));
        plan.push_back(stim_row(CMD_START, 0, 0, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(stim_row(CMD_REPLY, 0, ACK_BYTE, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(stim_row(CMD_REPLY, 0, ACK_BYTE, 0));
        repeat (5) plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(known_row(CMD_REPLY, 0, ACK_BYTE, 0, 0, 8'h00, ST_DONE, 0));
        // Largest erase count, only its opening bytes.
        plan.push_back(regs_row(16'hFFFF, 32'h0000_0000));
        plan.push_back(stim_row(CMD_START, 24'd300, 0, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(stim_row(CMD_REPLY, 0, ACK_BYTE, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(stim_row(CMD_READY, 0, 0, 0));
        plan.push_back(stim_row(CMD_REPLY, 0, ACK_BYTE, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 1, 8'hFF, ST_SENDING, 0));
        plan.push_back(known_row(CMD_READY, 0, 0, 0, 1, 8'hFF, ST_SENDING, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_regs)
                set_regs(plan[i].erase_val, plan[i].addr_val);
            else
                send_item(plan[i].cmd, plan[i].len, plan[i].rep, plan[i].dat,
                          plan[i].known, plan[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin e = 16'd0; a = 32'h0000_0000; end
                1:       begin e = 16'd1; a = 32'hFFFF_FF00; end   // address wraps
                2:       begin e = 16'($urandom_range(0, 3)); a = $urandom; end
                default: begin e = 16'd0; a = 32'hFFFF_FFFF; end
            endcase
            set_regs(e, a);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                len = 24'($urandom);
                rep = 8'($urandom);
                dat = 8'($urandom);
                if ($urandom_range(0, 49) == 0)
                    cmd = ($urandom_range(0, 19) == 0) ? CMD_START : 2'($urandom_range(1, 3));
                else
                begin
                    case (ph)
                        P_IDLE, P_DONE, P_NACK, P_UNK:
                        begin
                            cmd  = CMD_START;
                            pick = $urandom_range(0, 31);
                            if (pick < 3)
                                len = '0;
                            else if (pick != 31)
                                len = 24'($urandom_range(1, 2 * PAGE_BYTES));
                        end
                        P_W_SYNC, P_W_ECMD, P_W_ELIST, P_W_WCMD, P_W_ADDR, P_W_PAGE:
                        begin
                            cmd  = CMD_REPLY;
                            pick = $urandom_range(0, 99);
                            if (pick < 96)
                                rep = ACK_BYTE;
                            else if (pick < 98)
                                rep = NACK_BYTE;
                        end
                        P_PAGE:
                            cmd = (step >= 1 && step <= PAGE_BYTES) ? CMD_IMAGE : CMD_READY;
                        default:
                            cmd = CMD_READY;
                    endcase
                end
                send_item(cmd, len, rep, dat, 1'b0, '0);
                if (acted)
                    counted++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ubfp_pkg.sv
rtl/ubfp_core.sv
rtl/uart_bootloader_flash_programmer.sv
test/tb_uart_bootloader_flash_programmer.sv
